FILE: hw/rtl/six_digit_fade_slot_display_assert.svh
// Assertion macros used by the display checker.
`ifndef SIX_DIGIT_FADE_SLOT_DISPLAY_ASSERT_SVH
`define SIX_DIGIT_FADE_SLOT_DISPLAY_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define SDFSD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("six digit display: check failed");

// Check a property on every clock edge, reset included.
`define SDFSD_ASSERT_NORST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("six digit display: reset check failed");

`endif

FILE: hw/rtl/sdfsd_pkg.sv
`default_nettype none

package sdfsd_pkg;

    // Display geometry
    localparam int DIGITS  = 6;
    localparam int DIGIT_W = 8;
    localparam int PHASE_W = 8;
    localparam int DUR_W   = 16;
    localparam int ROLL_W  = 4;

    // PWM phases per period, also the crossfade resolution
    localparam int FADE_LEVELS = 16;
    localparam int FADE_QW     = $clog2(FADE_LEVELS);

    // Divider sizing: quotient bits (at least two) and remainder width
    localparam int DIV_QW = (FADE_QW > 2) ? FADE_QW : 2;
    localparam int DIV_CW = $clog2(DIV_QW);
    localparam int REM_W  = DUR_W + DIV_QW;

    // Digit codes and slot timing
    localparam logic [DIGIT_W-1:0] BLANK     = 8'd255;
    localparam logic [DIGIT_W-1:0] MAX_DIGIT = 8'd9;
    localparam logic [DUR_W-1:0]   SLOT_DEFAULT_MS = 16'd300;
    localparam logic [DUR_W-1:0]   SLOT_DIVISOR    = 16'd10;
    // duration / SLOT_DIVISOR as (duration * SLOT_RECIP) >> SLOT_RECIP_SH,
    // exact for every 16-bit duration
    localparam logic [DUR_W-1:0]   SLOT_RECIP      = 16'd52429;
    localparam int                 SLOT_RECIP_SH   = 19;
    localparam logic [7:0]         ROLL_MIN   = 8'd20;
    localparam logic [7:0]         ROLL_MAX   = 8'd250;
    localparam logic [7:0]         ROLL_RESET = 8'd50;
    localparam logic [ROLL_W-1:0]  ROLL_STEPS = 4'd10;
    localparam logic [7:0]         BRIGHT_RESET = 8'd16;

    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_SET  = 2'd1,
        CMD_FADE = 2'd2,
        CMD_SLOT = 2'd3
    } cmd_t;

    typedef logic [DIGIT_W-1:0] digit_t;
    typedef logic [DIGITS-1:0][DIGIT_W-1:0] digits_t;

    typedef struct packed {
        logic              start;
        logic [DIV_CW-1:0] top_bit;
    } div_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_sts_t;

    // Anything above nine shows as zero
    function automatic digit_t clip_digit(digit_t d);
        return (d > MAX_DIGIT) ? '0 : d;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/six_digit_fade_slot_display.sv
// Channel  Direction  Signals                               Moves
// s_       in         s_valid s_ready s_cmd s_count ...     one command beat
// m_       out        m_valid m_ready m_shown_0..5          six digits to light
// cfg_     in         cfg_valid cfg_ready cfg_brightness    brightness write
//
// Set digits, start crossfade and start slot finish on acceptance; the slot step
// interval comes from a reciprocal multiply. A tick ends on acceptance when idle
// and dark, else it passes prep, then for a crossfade the share from the serial
// divider (one bit per cycle), then render. s_ready is low while a beat is
// in work. Synchronous active low reset; no clearing pass. A finished result
// waits in the output register while commands go on; only a tick with a new
// result waits for it to drain.
`default_nettype none

module six_digit_fade_slot_display (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [1:0]                       s_cmd,
    input  wire logic [2:0]                       s_count,
    input  wire logic [15:0]                      s_duration_ms,
    input  wire logic [7:0]                       s_digit_0,
    input  wire logic [7:0]                       s_digit_1,
    input  wire logic [7:0]                       s_digit_2,
    input  wire logic [7:0]                       s_digit_3,
    input  wire logic [7:0]                       s_digit_4,
    input  wire logic [7:0]                       s_digit_5,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [7:0]                            m_shown_0,
    output logic [7:0]                            m_shown_1,
    output logic [7:0]                            m_shown_2,
    output logic [7:0]                            m_shown_3,
    output logic [7:0]                            m_shown_4,
    output logic [7:0]                            m_shown_5,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [7:0]                       cfg_brightness
);

    typedef enum logic [1:0] {
        MD_STILL,
        MD_FADE,
        MD_ROLL
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_FDIV,
        ST_RENDER
    } state_t;

    localparam int PW = sdfsd_pkg::PHASE_W;
    localparam int DW = sdfsd_pkg::DUR_W;

    state_t                              state_reg;
    mode_t                               mode_reg;
    logic [7:0]                          brightness_reg;
    sdfsd_pkg::digits_t                  current_reg;
    sdfsd_pkg::digits_t                  target_reg;
    sdfsd_pkg::digits_t                  last_reg;
    logic [sdfsd_pkg::DIGITS-1:0][sdfsd_pkg::ROLL_W-1:0] steps_reg;
    logic [DW-1:0]                       length_reg;
    logic [DW-1:0]                       elapsed_reg;
    logic [PW-1:0]                       phase_reg;
    logic [7:0]                          interval_reg;
    logic [7:0]                          rcount_reg;
    logic [PW-1:0]                       prog_reg;
    logic                                m_valid_reg;
    sdfsd_pkg::digits_t                  m_shown_reg;

    logic                                accept;
    sdfsd_pkg::cmd_t                     cmd;
    logic [2:0]                          count_c;
    sdfsd_pkg::digits_t                  in_digits;
    sdfsd_pkg::digits_t                  set_digits;
    sdfsd_pkg::digits_t                  clip_digits;
    logic [sdfsd_pkg::DIGITS-1:0][sdfsd_pkg::ROLL_W-1:0] slot_steps;
    logic                                slot_any;
    logic [DW-1:0]                       dur_slot;
    logic [DW-1:0]                       dur_fade;
    logic [31:0]                         slot_prod;
    logic [DW-1:0]                       slot_tenth;
    logic [PW-1:0]                       duty;
    logic [PW-1:0]                       phase_next;
    logic [DW-1:0]                       elapsed_next;
    logic [7:0]                          rcount_next;
    sdfsd_pkg::digits_t                  roll_digits;
    logic [sdfsd_pkg::DIGITS-1:0][sdfsd_pkg::ROLL_W-1:0] roll_steps;
    logic                                roll_active;
    logic [PW-1:0]                       prog_next;
    logic [7:0]                          interval_next;
    logic [PW-1:0]                       thresh;
    logic                                out_free;
    logic                                emit;

    sdfsd_pkg::div_ctl_t                 div_ctl;
    sdfsd_pkg::div_sts_t                 div_sts;
    logic [sdfsd_pkg::REM_W-1:0]         div_numer;
    logic [DW-1:0]                       div_denom;
    logic [sdfsd_pkg::DIV_QW-1:0]        div_quot;

    sdfsd_pkg::digits_t                  shown;
    logic                                changed;

    assign in_digits = {s_digit_5, s_digit_4, s_digit_3, s_digit_2, s_digit_1, s_digit_0};

    // Decode the beat and precompute every command's update
    always_comb begin
        s_ready  = (state_reg == ST_IDLE);
        accept   = s_valid && s_ready;
        cmd      = sdfsd_pkg::cmd_t'(s_cmd);
        count_c  = (s_count > 3'd6) ? 3'd6 : s_count;
        dur_slot = (s_duration_ms == '0) ? sdfsd_pkg::SLOT_DEFAULT_MS : s_duration_ms;
        dur_fade = (s_duration_ms < DW'(sdfsd_pkg::FADE_LEVELS))
                 ? DW'(sdfsd_pkg::FADE_LEVELS) : s_duration_ms;
        slot_any = 1'b0;
        for (int i = 0; i < sdfsd_pkg::DIGITS; i++) begin
            clip_digits[i] = sdfsd_pkg::clip_digit(in_digits[i]);
            set_digits[i]  = (in_digits[i] == sdfsd_pkg::BLANK)
                           ? sdfsd_pkg::BLANK : clip_digits[i];
            if (current_reg[i] != sdfsd_pkg::BLANK && current_reg[i] != clip_digits[i]) begin
                slot_steps[i] = sdfsd_pkg::ROLL_STEPS;
                slot_any      = 1'b1;
            end else begin
                slot_steps[i] = '0;
            end
        end
        // Slot step interval: a tenth of the duration, clamped
        slot_prod  = 32'(dur_slot) * 32'(sdfsd_pkg::SLOT_RECIP);
        slot_tenth = DW'(slot_prod >> sdfsd_pkg::SLOT_RECIP_SH);
        if (slot_tenth < DW'(sdfsd_pkg::ROLL_MIN)) begin
            interval_next = sdfsd_pkg::ROLL_MIN;
        end else if (slot_tenth > DW'(sdfsd_pkg::ROLL_MAX)) begin
            interval_next = sdfsd_pkg::ROLL_MAX;
        end else begin
            interval_next = slot_tenth[7:0];
        end
    end

    // Tick arithmetic: phase, counters and one roll step
    always_comb begin
        duty = (brightness_reg > PW'(sdfsd_pkg::FADE_LEVELS))
             ? PW'(sdfsd_pkg::FADE_LEVELS) : brightness_reg;
        phase_next = (phase_reg == PW'(sdfsd_pkg::FADE_LEVELS - 1))
                   ? '0 : phase_reg + 1'b1;
        elapsed_next = elapsed_reg + 1'b1;
        rcount_next  = rcount_reg + 1'b1;
        roll_active  = 1'b0;
        for (int i = 0; i < sdfsd_pkg::DIGITS; i++) begin
            roll_digits[i] = current_reg[i];
            roll_steps[i]  = steps_reg[i];
            if (steps_reg[i] != '0) begin
                roll_active   = 1'b1;
                roll_steps[i] = steps_reg[i] - 1'b1;
                if (current_reg[i] <= sdfsd_pkg::MAX_DIGIT) begin
                    roll_digits[i] = (current_reg[i] == '0)
                                   ? sdfsd_pkg::MAX_DIGIT : current_reg[i] - 1'b1;
                end
            end
        end
    end

    // Feed the divider with the crossfade share from prep
    always_comb begin
        div_numer       = sdfsd_pkg::REM_W'(elapsed_reg)
                        * sdfsd_pkg::REM_W'(sdfsd_pkg::FADE_LEVELS);
        div_denom       = length_reg;
        div_ctl.top_bit = sdfsd_pkg::DIV_CW'(sdfsd_pkg::FADE_QW - 1);
        div_ctl.start   = (state_reg == ST_PREP) && (mode_reg == MD_FADE);
        // The share stays below FADE_LEVELS while a crossfade runs
        prog_next = PW'(div_quot);
        thresh    = PW'(sdfsd_pkg::FADE_LEVELS) - prog_reg;
        out_free  = !m_valid_reg || m_ready;
        emit      = (state_reg == ST_RENDER) && changed && out_free;
    end

    sdfsd_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (div_ctl),
        .numer   (div_numer),
        .denom   (div_denom),
        .sts     (div_sts),
        .quot    (div_quot)
    );

    sdfsd_render u_render (
        .cur     (current_reg),
        .tgt     (target_reg),
        .last    (last_reg),
        .fade    (mode_reg == MD_FADE),
        .phase   (phase_reg),
        .duty    (duty),
        .thresh  (thresh),
        .shown   (shown),
        .changed (changed)
    );

    // Sequencer, display state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            mode_reg       <= MD_STILL;
            brightness_reg <= sdfsd_pkg::BRIGHT_RESET;
            current_reg    <= '0;
            target_reg     <= '0;
            steps_reg      <= '0;
            last_reg       <= {sdfsd_pkg::DIGITS{sdfsd_pkg::BLANK}};
            length_reg     <= '0;
            elapsed_reg    <= '0;
            phase_reg      <= '0;
            interval_reg   <= sdfsd_pkg::ROLL_RESET;
            rcount_reg     <= '0;
            prog_reg       <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid) begin
                brightness_reg <= cfg_brightness;
            end
            // Raise the result on a new set, drop it once the sink takes it
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        unique case (cmd)
                            sdfsd_pkg::CMD_TICK: begin
                                phase_reg <= phase_next;
                                if (mode_reg == MD_FADE) begin
                                    elapsed_reg <= elapsed_next;
                                    if (elapsed_next >= length_reg) begin
                                        current_reg <= target_reg;
                                        mode_reg    <= MD_STILL;
                                    end
                                    state_reg <= ST_PREP;
                                end else if (mode_reg == MD_ROLL) begin
                                    elapsed_reg <= elapsed_next;
                                    if (rcount_next < interval_reg) begin
                                        rcount_reg <= rcount_next;
                                    end else begin
                                        rcount_reg <= '0;
                                        if (roll_active) begin
                                            current_reg <= roll_digits;
                                            steps_reg   <= roll_steps;
                                        end else begin
                                            current_reg <= target_reg;
                                            mode_reg    <= MD_STILL;
                                        end
                                    end
                                    state_reg <= ST_PREP;
                                end else if (brightness_reg != '0) begin
                                    state_reg <= ST_PREP;
                                end
                            end
                            sdfsd_pkg::CMD_SET: begin
                                for (int i = 0; i < sdfsd_pkg::DIGITS; i++) begin
                                    if (3'(i) < count_c) begin
                                        current_reg[i] <= set_digits[i];
                                        target_reg[i]  <= set_digits[i];
                                        steps_reg[i]   <= '0;
                                    end
                                end
                                mode_reg <= MD_STILL;
                            end
                            sdfsd_pkg::CMD_FADE: begin
                                target_reg  <= clip_digits;
                                steps_reg   <= '0;
                                mode_reg    <= MD_FADE;
                                length_reg  <= dur_fade;
                                elapsed_reg <= '0;
                            end
                            sdfsd_pkg::CMD_SLOT: begin
                                target_reg <= clip_digits;
                                steps_reg  <= slot_steps;
                                if (slot_any) begin
                                    rcount_reg   <= '0;
                                    mode_reg     <= MD_ROLL;
                                    length_reg   <= dur_slot;
                                    elapsed_reg  <= '0;
                                    interval_reg <= interval_next;
                                end
                            end
                            default: begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_PREP: begin
                    state_reg <= (mode_reg == MD_FADE) ? ST_FDIV : ST_RENDER;
                end
                ST_FDIV: begin
                    if (div_sts.done) begin
                        prog_reg  <= prog_next;
                        state_reg <= ST_RENDER;
                    end
                end
                ST_RENDER: begin
                    // Emit only a changed set; hold until the output slot frees
                    if (!changed) begin
                        state_reg <= ST_IDLE;
                    end else if (out_free) begin
                        m_shown_reg <= shown;
                        last_reg    <= shown;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_shown_0 = m_shown_reg[0];
    assign m_shown_1 = m_shown_reg[1];
    assign m_shown_2 = m_shown_reg[2];
    assign m_shown_3 = m_shown_reg[3];
    assign m_shown_4 = m_shown_reg[4];
    assign m_shown_5 = m_shown_reg[5];

endmodule

`default_nettype wire

FILE: hw/rtl/sdfsd_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle from top_bit down to bit 0.
// The caller guarantees the quotient fits below bit top_bit + 1.
module sdfsd_div (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire sdfsd_pkg::div_ctl_t              ctl,
    input  wire logic [sdfsd_pkg::REM_W-1:0]      numer,
    input  wire logic [sdfsd_pkg::DUR_W-1:0]      denom,
    output sdfsd_pkg::div_sts_t                   sts,
    output logic [sdfsd_pkg::DIV_QW-1:0]          quot
);

    logic                           busy_reg;
    logic                           done_reg;
    logic [sdfsd_pkg::DIV_CW-1:0]   bit_reg;
    logic [sdfsd_pkg::REM_W-1:0]    rem_reg;
    logic [sdfsd_pkg::REM_W-1:0]    dsh_reg;
    logic [sdfsd_pkg::DIV_QW-1:0]   quot_reg;
    logic                           fits;
    logic [sdfsd_pkg::REM_W-1:0]    rem_next;

    // Trial subtract against the shifted divisor
    always_comb begin
        fits     = (rem_reg >= dsh_reg);
        rem_next = fits ? (rem_reg - dsh_reg) : rem_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            // Pulse done on the cycle after the last quotient bit
            done_reg <= !ctl.start && busy_reg && (bit_reg == '0);
            if (ctl.start) begin
                busy_reg <= 1'b1;
                bit_reg  <= ctl.top_bit;
                rem_reg  <= numer;
                dsh_reg  <= sdfsd_pkg::REM_W'(denom) << ctl.top_bit;
                quot_reg <= '0;
            end else if (busy_reg) begin
                rem_reg  <= rem_next;
                quot_reg <= {quot_reg[sdfsd_pkg::DIV_QW-2:0], fits};
                dsh_reg  <= dsh_reg >> 1;
                if (bit_reg == '0) begin
                    busy_reg <= 1'b0;
                end else begin
                    bit_reg <= bit_reg - 1'b1;
                end
            end
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign quot     = quot_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/sdfsd_render.sv
`default_nettype none

// Pick the digit to light in this PWM phase and flag a change.
module sdfsd_render (
    input  wire sdfsd_pkg::digits_t               cur,
    input  wire sdfsd_pkg::digits_t               tgt,
    input  wire sdfsd_pkg::digits_t               last,
    input  wire logic                             fade,
    input  wire logic [sdfsd_pkg::PHASE_W-1:0]    phase,
    input  wire logic [sdfsd_pkg::PHASE_W-1:0]    duty,
    input  wire logic [sdfsd_pkg::PHASE_W-1:0]    thresh,
    output sdfsd_pkg::digits_t                    shown,
    output logic                                  changed
);

    logic dark;

    always_comb begin
        dark    = (duty == '0) || (phase >= duty);
        changed = 1'b0;
        for (int i = 0; i < sdfsd_pkg::DIGITS; i++) begin
            if (dark) begin
                shown[i] = sdfsd_pkg::BLANK;
            end else if (fade) begin
                shown[i] = (phase < thresh) ? cur[i] : tgt[i];
            end else begin
                shown[i] = cur[i];
            end
            if (shown[i] != last[i]) begin
                changed = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/sdfsd_checker.sv
`default_nettype none

`include "six_digit_fade_slot_display_assert.svh"

// Port-level checks for the six digit display
module sdfsd_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire logic [1:0] s_cmd,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [7:0] m_shown_0,
    input wire logic [7:0] m_shown_1,
    input wire logic [7:0] m_shown_2,
    input wire logic [7:0] m_shown_3,
    input wire logic [7:0] m_shown_4,
    input wire logic [7:0] m_shown_5
);

    // A stalled result beat holds its digits
    `SDFSD_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_shown_0) && $stable(m_shown_1) && $stable(m_shown_2) && $stable(m_shown_3) && $stable(m_shown_4) && $stable(m_shown_5))

    // A new result only comes out of a tick in work, never while idle
    `SDFSD_ASSERT(a_emit_busy, aclk, aresetn, $rose(m_valid) |-> !$past(s_ready))

    // Commands other than a tick never produce a result
    `SDFSD_ASSERT(a_cmd_silent, aclk, aresetn, s_valid && s_ready && (s_cmd != sdfsd_pkg::CMD_TICK) |=> !$rose(m_valid))

    // Reset empties the output register
    `SDFSD_ASSERT_NORST(a_reset_empty, aclk, !aresetn |=> !m_valid)

endmodule

bind six_digit_fade_slot_display sdfsd_checker u_sdfsd_checker (.*);

`default_nettype wire

FILE: tb/six_digit_fade_slot_display_test.sv
`timescale 1ns / 1ps

module six_digit_fade_slot_display_test;

    typedef enum logic [1:0] {
        ANIM_IDLE = 2'd0,
        ANIM_FADE = 2'd1,
        ANIM_SLOT = 2'd2
    } anim_mode_t;

    typedef struct packed {
        sdfsd_pkg::cmd_t    cmd;
        logic [2:0]         count;
        logic [15:0]        dur;
        sdfsd_pkg::digits_t digit;
    } disp_beat_t;

    // Longest beat is a crossfade tick, well under this
    localparam int SETTLE_CYCLES = 50;
    localparam int PHASE_BEATS   = 170;

    logic        aclk           = 1'b0;
    logic        aresetn        = 1'b0;
    logic        s_valid        = 1'b0;
    logic [1:0]  s_cmd          = '0;
    logic [2:0]  s_count        = '0;
    logic [15:0] s_duration_ms  = '0;
    logic [7:0]  s_digit_0      = '0;
    logic [7:0]  s_digit_1      = '0;
    logic [7:0]  s_digit_2      = '0;
    logic [7:0]  s_digit_3      = '0;
    logic [7:0]  s_digit_4      = '0;
    logic [7:0]  s_digit_5      = '0;
    logic        m_ready        = 1'b0;
    logic        cfg_valid      = 1'b0;
    logic [7:0]  cfg_brightness = '0;
    wire logic       s_ready;
    wire logic       m_valid;
    wire logic [7:0] m_shown_0, m_shown_1, m_shown_2, m_shown_3, m_shown_4, m_shown_5;
    wire logic       cfg_ready;

    six_digit_fade_slot_display DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_count        (s_count),
        .s_duration_ms  (s_duration_ms),
        .s_digit_0      (s_digit_0),
        .s_digit_1      (s_digit_1),
        .s_digit_2      (s_digit_2),
        .s_digit_3      (s_digit_3),
        .s_digit_4      (s_digit_4),
        .s_digit_5      (s_digit_5),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_shown_0      (m_shown_0),
        .m_shown_1      (m_shown_1),
        .m_shown_2      (m_shown_2),
        .m_shown_3      (m_shown_3),
        .m_shown_4      (m_shown_4),
        .m_shown_5      (m_shown_5),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_brightness (cfg_brightness)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Display model state, starting from the reset values
    sdfsd_pkg::digit_t disp_cur   [sdfsd_pkg::DIGITS] = '{default: 8'd0};
    sdfsd_pkg::digit_t disp_tgt   [sdfsd_pkg::DIGITS] = '{default: 8'd0};
    sdfsd_pkg::digit_t last_lit   [sdfsd_pkg::DIGITS] = '{default: sdfsd_pkg::BLANK};
    logic [3:0]        rolls_left [sdfsd_pkg::DIGITS] = '{default: 4'd0};
    anim_mode_t  mode        = ANIM_IDLE;
    logic [15:0] anim_len    = '0;
    logic [15:0] elapsed_ms  = '0;
    logic [7:0]  phase       = '0;
    logic [7:0]  roll_period = sdfsd_pkg::ROLL_RESET;
    logic [7:0]  roll_count  = '0;
    logic [7:0]  bright      = sdfsd_pkg::BRIGHT_RESET;

    disp_beat_t          pending_beats [$];
    sdfsd_pkg::digits_t  lit_expected  [$];
    disp_beat_t  beat_now;
    int          beats_owed  = 0;
    int          send_gap    = 0;
    int          recv_gap    = 0;
    bit          send_steady = 1'b0;
    bit          recv_steady = 1'b0;
    int          mismatches  = 0;
    int          results_seen = 0;

    function automatic sdfsd_pkg::digit_t to_decimal(input sdfsd_pkg::digit_t d);
        return (d > sdfsd_pkg::MAX_DIGIT) ? 8'd0 : d;
    endfunction

    function automatic void snap_to_target();
        for (int i = 0; i < sdfsd_pkg::DIGITS; i++) disp_cur[i] = disp_tgt[i];
        mode = ANIM_IDLE;
    endfunction

    // Advance the display model by one beat and queue the digits it lights
    task automatic predict_beat(input disp_beat_t b);
        sdfsd_pkg::digits_t lit;
        logic [31:0]        prog, level, duty, span, roll_step;
        logic [2:0]         n;
        logic               active, changed;
        sdfsd_pkg::digit_t  t;
        case (b.cmd)
            sdfsd_pkg::CMD_TICK: begin
                phase = 8'((32'(phase) + 1) % sdfsd_pkg::FADE_LEVELS);
                if (mode == ANIM_FADE) begin
                    elapsed_ms = elapsed_ms + 16'd1;
                    if (elapsed_ms >= anim_len) snap_to_target();
                end else if (mode == ANIM_SLOT) begin
                    elapsed_ms = elapsed_ms + 16'd1;
                    roll_count = roll_count + 8'd1;
                    if (roll_count >= roll_period) begin
                        roll_count = '0;
                        active = 1'b0;
                        for (int i = 0; i < sdfsd_pkg::DIGITS; i++) begin
                            if (rolls_left[i] != 0) begin
                                active = 1'b1;
                                if (disp_cur[i] <= sdfsd_pkg::MAX_DIGIT)
                                    disp_cur[i] = 8'((32'(disp_cur[i]) + 9) % 10);
                                rolls_left[i] = rolls_left[i] - 4'd1;
                            end
                        end
                        if (!active) snap_to_target();
                    end
                end else if (bright == 8'd0) begin
                    return;
                end
                // Crossfade: early phases show the old digits
                level = 0;
                if (mode == ANIM_FADE && anim_len != 0) begin
                    prog = 32'(elapsed_ms) * sdfsd_pkg::FADE_LEVELS / 32'(anim_len);
                    if (prog > sdfsd_pkg::FADE_LEVELS) prog = sdfsd_pkg::FADE_LEVELS;
                    level = sdfsd_pkg::FADE_LEVELS - prog;
                end
                duty = (bright > sdfsd_pkg::FADE_LEVELS) ? sdfsd_pkg::FADE_LEVELS
                                                         : 32'(bright);
                changed = 1'b0;
                for (int i = 0; i < sdfsd_pkg::DIGITS; i++) begin
                    if (duty == 0 || phase >= duty)
                        lit[i] = sdfsd_pkg::BLANK;
                    else if (mode == ANIM_FADE)
                        lit[i] = (phase < level) ? disp_cur[i] : disp_tgt[i];
                    else
                        lit[i] = disp_cur[i];
                    if (lit[i] != last_lit[i]) changed = 1'b1;
                end
                if (changed) begin
                    for (int i = 0; i < sdfsd_pkg::DIGITS; i++) last_lit[i] = lit[i];
                    lit_expected.push_back(lit);
                end
            end
            sdfsd_pkg::CMD_SET: begin
                n = (b.count > 3'd6) ? 3'd6 : b.count;
                for (int i = 0; i < n; i++) begin
                    disp_cur[i] = (b.digit[i] == sdfsd_pkg::BLANK) ? sdfsd_pkg::BLANK
                                                                   : to_decimal(b.digit[i]);
                    disp_tgt[i] = disp_cur[i];
                    rolls_left[i] = '0;
                end
                mode = ANIM_IDLE;
            end
            sdfsd_pkg::CMD_FADE: begin
                span = (b.dur < sdfsd_pkg::FADE_LEVELS) ? sdfsd_pkg::FADE_LEVELS
                                                        : 32'(b.dur);
                for (int i = 0; i < sdfsd_pkg::DIGITS; i++) begin
                    disp_tgt[i] = to_decimal(b.digit[i]);
                    rolls_left[i] = '0;
                end
                mode = ANIM_FADE;
                anim_len = 16'(span);
                elapsed_ms = '0;
            end
            default: begin
                span = (b.dur == 16'd0) ? 32'(sdfsd_pkg::SLOT_DEFAULT_MS) : 32'(b.dur);
                active = 1'b0;
                for (int i = 0; i < sdfsd_pkg::DIGITS; i++) begin
                    t = to_decimal(b.digit[i]);
                    disp_tgt[i] = t;
                    if (disp_cur[i] != sdfsd_pkg::BLANK && disp_cur[i] != t) begin
                        rolls_left[i] = sdfsd_pkg::ROLL_STEPS;
                        active = 1'b1;
                    end else begin
                        rolls_left[i] = '0;
                    end
                end
                // No digit changes: keep the mode as it was
                if (active) begin
                    roll_step = span / 32'(sdfsd_pkg::SLOT_DIVISOR);
                    if (roll_step < sdfsd_pkg::ROLL_MIN) roll_step = sdfsd_pkg::ROLL_MIN;
                    if (roll_step > sdfsd_pkg::ROLL_MAX) roll_step = sdfsd_pkg::ROLL_MAX;
                    roll_period = 8'(roll_step);
                    roll_count = '0;
                    mode = ANIM_SLOT;
                    anim_len = 16'(span);
                    elapsed_ms = '0;
                end
            end
        endcase
    endtask

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("MISMATCH: %s", msg);
    endtask

    function automatic int pick_gap(input bit steady);
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic sdfsd_pkg::digit_t rand_digit();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return sdfsd_pkg::digit_t'($urandom_range(0, 9));
        if (r < 85) return sdfsd_pkg::BLANK;
        return sdfsd_pkg::digit_t'($urandom_range(0, 255));
    endfunction

    task automatic queue_beat(input sdfsd_pkg::cmd_t c, input logic [2:0] n,
                              input logic [15:0] dur, input sdfsd_pkg::digits_t d);
        disp_beat_t b;
        b.cmd = c;
        b.count = n;
        b.dur = dur;
        b.digit = d;
        pending_beats.push_back(b);
        beats_owed++;
    endtask

    // Tick with noise on the fields it ignores
    task automatic queue_tick();
        queue_beat(sdfsd_pkg::CMD_TICK, 3'($urandom), 16'($urandom),
                   48'({$urandom, $urandom}));
    endtask

    // One animation scene: optional set, a fade or slot start, then ticks
    task automatic queue_scene();
        sdfsd_pkg::digits_t d;
        int                 kind, ticks;
        logic [15:0]        dur;
        if ($urandom_range(0, 99) < 35) begin
            for (int i = 0; i < sdfsd_pkg::DIGITS; i++) d[i] = rand_digit();
            queue_beat(sdfsd_pkg::CMD_SET, 3'($urandom_range(0, 7)), 16'($urandom), d);
        end
        for (int i = 0; i < sdfsd_pkg::DIGITS; i++) d[i] = rand_digit();
        kind = $urandom_range(0, 99);
        if (kind < 45) begin
            dur = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 80));
            queue_beat(sdfsd_pkg::CMD_FADE, 3'($urandom), dur, d);
            ticks = $urandom_range(4, 90);
        end else if (kind < 85) begin
            dur = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 250));
            queue_beat(sdfsd_pkg::CMD_SLOT, 3'($urandom), dur, d);
            // Half the rolls get long runs of ticks that can reach the end, the rest get cut short
            ticks = $urandom_range(0, 1) ? $urandom_range(230, 340) : $urandom_range(5, 120);
        end else begin
            ticks = $urandom_range(1, 40);
        end
        repeat (ticks) queue_tick();
    endtask

    // Hold until every beat is taken and every result is back, then settle
    task automatic wait_drained();
        do @(posedge aclk); while (beats_owed != 0 || lit_expected.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_brightness(input logic [7:0] v);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_brightness <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        bright = v;
    endtask

    // Command driver: present the next pending beat, predict on acceptance
    always @(posedge aclk) begin : beat_driver
        logic present;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_beat(beat_now);
                beats_owed--;
            end
            present = s_valid && !s_ready;
            if (!present) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_beats.size() != 0) begin
                    beat_now = pending_beats.pop_front();
                    s_cmd         <= beat_now.cmd;
                    s_count       <= beat_now.count;
                    s_duration_ms <= beat_now.dur;
                    s_digit_0     <= beat_now.digit[0];
                    s_digit_1     <= beat_now.digit[1];
                    s_digit_2     <= beat_now.digit[2];
                    s_digit_3     <= beat_now.digit[3];
                    s_digit_4     <= beat_now.digit[4];
                    s_digit_5     <= beat_now.digit[5];
                    present = 1'b1;
                    if ($urandom_range(0, 63) == 0) send_steady = !send_steady;
                    send_gap = pick_gap(send_steady);
                end
            end
            s_valid <= present;
        end
    end

    // Result monitor: compare each beat with the oldest expectation
    always @(posedge aclk) begin : lit_monitor
        sdfsd_pkg::digits_t got, want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                got = {m_shown_5, m_shown_4, m_shown_3, m_shown_2, m_shown_1, m_shown_0};
                if (lit_expected.size() == 0) begin
                    report_mismatch($sformatf("result %0d not expected: %h",
                                              results_seen, got));
                end else begin
                    want = lit_expected.pop_front();
                    for (int i = 0; i < sdfsd_pkg::DIGITS; i++) begin
                        if (got[i] !== want[i])
                            report_mismatch($sformatf("result %0d shown_%0d: got %0d want %0d",
                                                      results_seen, i, got[i], want[i]));
                    end
                end
                if ($urandom_range(0, 63) == 0) recv_steady = !recv_steady;
                recv_gap = pick_gap(recv_steady);
            end else if (!recv_steady && recv_gap == 0 && $urandom_range(0, 19) == 0) begin
                recv_gap = $urandom_range(1, 6);
            end
            if (recv_gap > 0) begin
                recv_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        logic [7:0] level_sel;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: clamps, blanks, count extremes, short fade, slot cases
        queue_tick();
        queue_beat(sdfsd_pkg::CMD_SET, 3'd6, 16'd0,
                   {8'd200, 8'd255, 8'd254, 8'd10, 8'd9, 8'd0});
        queue_tick();
        queue_beat(sdfsd_pkg::CMD_SET, 3'd7, 16'hFFFF,
                   {8'd6, 8'd5, 8'd4, 8'd3, 8'd2, 8'd1});
        queue_beat(sdfsd_pkg::CMD_SET, 3'd0, 16'd0, {6{8'd7}});
        queue_tick();
        queue_beat(sdfsd_pkg::CMD_FADE, 3'd0, 16'd0,
                   {8'd7, 8'd0, 8'd3, 8'd12, 8'd9, 8'd255});
        repeat (16) queue_tick();
        // Same digits as shown: nothing rolls
        queue_beat(sdfsd_pkg::CMD_SLOT, 3'd0, 16'd0,
                   {8'd7, 8'd0, 8'd3, 8'd0, 8'd9, 8'd0});
        queue_beat(sdfsd_pkg::CMD_SLOT, 3'd5, 16'hFFFF,
                   {8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1});
        wait_drained();

        // Random scenes under several brightness settings
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: level_sel = 8'd0;
                1: level_sel = 8'd1;
                2: level_sel = 8'd255;
                3: level_sel = 8'd15;
                4: level_sel = 8'd16;
                default: level_sel = 8'($urandom_range(2, 254));
            endcase
            write_brightness(level_sel);
            begin : fill_phase
                int start;
                start = beats_owed;
                while (beats_owed - start < PHASE_BEATS) queue_scene();
            end
            wait_drained();
        end

        if (mismatches == 0) begin
            $display("six_digit_fade_slot_display verification clean");
        end else begin
            $display("six_digit_fade_slot_display verification failed");
        end
        $finish;
    end

    // Several times the slowest legal run
    initial begin : watchdog
        #(6_000_000);
        $display("six_digit_fade_slot_display verification failed");
        $finish;
    end

endmodule
